[hw/rtl/ihex_pkg.sv]
package ihex_pkg;

    localparam int CHAR_W  = 8;
    localparam int ADDR_W  = 20;
    localparam int BYTE_W  = 8;
    localparam int POS_W   = 10;
    localparam int FIELD_W = 16;

    localparam logic [CHAR_W-1:0] CHAR_COLON = 8'h3A;
    localparam logic [CHAR_W-1:0] CHAR_0     = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_9     = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_UA    = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UF    = 8'h46;
    localparam logic [CHAR_W-1:0] CHAR_LA    = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h66;

    localparam logic [7:0] REC_DATA = 8'h00;
    localparam logic [7:0] REC_EOF  = 8'h01;
    localparam logic [7:0] REC_SEG  = 8'h02;

    typedef struct packed {
        logic [ADDR_W-1:0] write_address;
        logic [BYTE_W-1:0] write_byte;
        logic              is_end;
    } t_result;

    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } t_digit;

    function automatic t_digit hex_digit(input logic [CHAR_W-1:0] c);
        t_digit       d;
        logic [7:0]   diff;
        d    = '{valid: 1'b0, value: 4'h0};
        diff = 8'h00;
        if (c >= CHAR_0 && c <= CHAR_9) begin
            diff    = c - CHAR_0;
            d.valid = 1'b1;
            d.value = diff[3:0];
        end else if (c >= CHAR_UA && c <= CHAR_UF) begin
            diff    = c - CHAR_UA + 8'd10;
            d.valid = 1'b1;
            d.value = diff[3:0];
        end else if (c >= CHAR_LA && c <= CHAR_LF) begin
            diff    = c - CHAR_LA + 8'd10;
            d.valid = 1'b1;
            d.value = diff[3:0];
        end
        return d;
    endfunction

endpackage

[hw/rtl/ihex_in_stage.sv]
module ihex_in_stage import ihex_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [CHAR_W-1:0] i_char_in,
    input  logic              i_advance,
    output logic              o_held,
    output logic [CHAR_W-1:0] o_char
);

    logic              r_valid;
    logic [CHAR_W-1:0] r_char;

    // slot frees up in the same cycle it is consumed
    assign o_ready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_char <= i_char_in;
        end
    end

    assign o_held = r_valid;
    assign o_char = r_char;

endmodule

[hw/rtl/ihex_core.sv]
module ihex_core import ihex_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [CHAR_W-1:0] i_char,
    output logic              o_has_result,
    output t_result           o_result
);

    logic               r_in_record;
    logic [POS_W-1:0]   r_pos;
    logic [FIELD_W-1:0] r_acc;
    logic               r_inv;
    logic [7:0]         r_len;
    logic [15:0]        r_addr;
    logic [7:0]         r_type;
    logic [15:0]        r_seg;
    logic [15:0]        r_first;
    logic               r_first_cap;
    logic               r_finished;

    logic               n_in_record;
    logic [POS_W-1:0]   n_pos;
    logic [FIELD_W-1:0] n_acc;
    logic               n_inv;
    logic [7:0]         n_len;
    logic [15:0]        n_addr;
    logic [7:0]         n_type;
    logic [15:0]        n_seg;
    logic [15:0]        n_first;
    logic               n_first_cap;
    logic               n_finished;

    logic [POS_W-1:0]   crc_pos;
    logic [POS_W-1:0]   data_idx;
    logic               seg_rec;
    logic               start;
    logic               in_data;
    t_digit             dig;
    logic [FIELD_W-1:0] acc_base;
    logic               inv_base;
    logic [FIELD_W-1:0] fold_acc;
    logic               fold_inv;
    logic [FIELD_W-1:0] fval;
    logic [15:0]        new_addr;
    logic [ADDR_W-1:0]  wr_addr;

    assign crc_pos  = POS_W'(8) + {1'b0, r_len, 1'b0};
    assign data_idx = r_pos - POS_W'(8);
    assign seg_rec  = (r_type == REC_SEG) && (r_len >= 8'd2);
    assign in_data  = (r_pos >= POS_W'(8)) && (r_pos < crc_pos);
    assign dig      = hex_digit(i_char);

    always_comb begin
        if (r_pos < POS_W'(8)) begin
            start = (r_pos == POS_W'(0)) || (r_pos == POS_W'(2)) || (r_pos == POS_W'(6));
        end else if (r_pos < crc_pos) begin
            start = !data_idx[0] && !(seg_rec && r_pos == POS_W'(10));
        end else begin
            start = (r_pos == crc_pos);
        end
    end

    assign acc_base = start ? '0 : r_acc;
    assign inv_base = start ? 1'b0 : r_inv;
    assign fold_acc = {acc_base[FIELD_W-5:0], dig.value};
    assign fold_inv = inv_base || !dig.valid;
    assign fval     = fold_inv ? '0 : fold_acc;
    assign new_addr = fval;

    // record offset plus segment base plus byte index, wraps at 1 MiB
    assign wr_addr = {4'h0, r_addr} - {4'h0, r_first} + {r_seg, 4'h0}
                   + {{(ADDR_W-POS_W+1){1'b0}}, data_idx[POS_W-1:1]};

    always_comb begin
        n_in_record  = r_in_record;
        n_pos        = r_pos;
        n_acc        = r_acc;
        n_inv        = r_inv;
        n_len        = r_len;
        n_addr       = r_addr;
        n_type       = r_type;
        n_seg        = r_seg;
        n_first      = r_first;
        n_first_cap  = r_first_cap;
        n_finished   = r_finished;
        o_has_result = 1'b0;
        o_result     = '{write_address: '0, write_byte: '0, is_end: 1'b0};

        if (!r_finished) begin
            if (!r_in_record) begin
                if (i_char == CHAR_COLON) begin
                    n_in_record = 1'b1;
                    n_pos       = '0;
                    n_acc       = '0;
                    n_inv       = 1'b0;
                end
            end else begin
                n_acc = fold_acc;
                n_inv = fold_inv;
                n_pos = r_pos + POS_W'(1);
                if (r_pos == POS_W'(1)) begin
                    n_len = fval[7:0];
                end else if (r_pos == POS_W'(5)) begin
                    n_addr = new_addr;
                    if (!r_first_cap) begin
                        n_first     = new_addr;
                        n_first_cap = 1'b1;
                    end
                end else if (r_pos == POS_W'(7)) begin
                    n_type = fval[7:0];
                end else if (in_data) begin
                    if (r_type == REC_DATA && data_idx[0]) begin
                        o_has_result = 1'b1;
                        o_result     = '{write_address: wr_addr, write_byte: fval[7:0],
                                         is_end: 1'b0};
                    end else if (seg_rec && r_pos == POS_W'(11)) begin
                        n_seg = fval;
                    end
                end else if (r_pos == crc_pos + POS_W'(1)) begin
                    n_in_record = 1'b0;
                    if (r_type == REC_EOF) begin
                        o_has_result = 1'b1;
                        o_result     = '{write_address: '0, write_byte: '0, is_end: 1'b1};
                        n_finished   = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_record <= 1'b0;
            r_pos       <= '0;
            r_acc       <= '0;
            r_inv       <= 1'b0;
            r_len       <= '0;
            r_addr      <= '0;
            r_type      <= '0;
            r_seg       <= '0;
            r_first     <= '0;
            r_first_cap <= 1'b0;
            r_finished  <= 1'b0;
        end else if (i_step) begin
            r_in_record <= n_in_record;
            r_pos       <= n_pos;
            r_acc       <= n_acc;
            r_inv       <= n_inv;
            r_len       <= n_len;
            r_addr      <= n_addr;
            r_type      <= n_type;
            r_seg       <= n_seg;
            r_first     <= n_first;
            r_first_cap <= n_first_cap;
            r_finished  <= n_finished;
        end
    end

endmodule

[hw/rtl/ihex_out_stage.sv]
module ihex_out_stage import ihex_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  t_result           i_result,
    output logic              o_free,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [ADDR_W-1:0] o_write_address,
    output logic [BYTE_W-1:0] o_write_byte,
    output logic              o_is_end
);

    logic    r_valid;
    t_result r_result;

    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid         = r_valid;
    assign o_write_address = r_result.write_address;
    assign o_write_byte    = r_result.write_byte;
    assign o_is_end        = r_result.is_end;

endmodule

[hw/rtl/intel_hex_record_parser_top.sv]
// channel   direction  handshake           payload
// input     in         i_valid / o_ready   i_char_in[7:0]
// result    out        o_valid / i_ready   o_write_address[19:0], o_write_byte[7:0], o_is_end
//
// one character per cycle sustained while the result side is not stalled; a result is
// offered from the result register once its character has passed the input register
// and the record step; the rate is set by the record step, which is combinational
// between the input register and the result register
// synchronous active-low reset clears the record state, segment and end flag
// a stalled result holds its register while the input register still takes one
// more character; characters that give no result never wait on the result side
module intel_hex_record_parser_top import ihex_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [CHAR_W-1:0] i_char_in,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [ADDR_W-1:0] o_write_address,
    output logic [BYTE_W-1:0] o_write_byte,
    output logic              o_is_end
);

    logic              held;
    logic [CHAR_W-1:0] held_char;
    logic              out_free;
    logic              advance;
    logic              has_result;
    t_result           result;

    // a held character steps the parser unless it produces a result that the
    // result register cannot take yet
    assign advance = held && (out_free || !has_result);

    ihex_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_char_in (i_char_in),
        .i_advance (advance),
        .o_held    (held),
        .o_char    (held_char)
    );

    // record position tracking, field folding and write address generation
    ihex_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (advance),
        .i_char       (held_char),
        .o_has_result (has_result),
        .o_result     (result)
    );

    ihex_out_stage u_out (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_load          (advance && has_result),
        .i_result        (result),
        .o_free          (out_free),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_write_address (o_write_address),
        .o_write_byte    (o_write_byte),
        .o_is_end        (o_is_end)
    );

endmodule

[hw/rtl/ihex_checker.sv]
module ihex_checker import ihex_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_ready,
    input logic              o_valid,
    input logic              i_ready,
    input logic [ADDR_W-1:0] o_write_address,
    input logic [BYTE_W-1:0] o_write_byte,
    input logic              o_is_end
);

    // input side is open right after reset
    a_rst_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> o_ready)
        else $error("input not ready after reset");

    // stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result dropped while stalled");

    // stalled result payload holds
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(o_write_address) && $stable(o_write_byte)
                                && $stable(o_is_end))
        else $error("result payload changed while stalled");

    // end result carries zero address and byte
    a_end_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_is_end |-> o_write_address == '0 && o_write_byte == '0)
        else $error("end result with nonzero payload");

    // nothing follows the end result
    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_is_end && i_ready |=> !o_valid)
        else $error("result after end of file");

endmodule

bind intel_hex_record_parser_top ihex_checker u_checker (.*);

[tb/tb.sv]
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ihex_pkg::*;

    typedef logic [7:0] t_byte_q[$];

    // receiver behavior, each mode held for a random run before a new one is picked
    typedef enum int {
        READY_ALWAYS,
        READY_RANDOM,
        READY_EVERY_FOURTH,
        READY_RARE
    } t_ready_mode;

    // stop the random part a little short so the closing records fit the budget
    localparam int RANDOM_CHAR_TARGET = 1590;
    localparam int DRAIN_LIMIT        = 20000;
    localparam int TAIL_CYCLES        = 16;

    logic              i_clk           = 1'b0;
    logic              i_rst_n         = 1'b0;
    logic              i_valid         = 1'b0;
    logic              o_ready;
    logic [CHAR_W-1:0] i_char_in       = '0;
    logic              o_valid;
    logic              i_ready         = 1'b0;
    logic [ADDR_W-1:0] o_write_address;
    logic [BYTE_W-1:0] o_write_byte;
    logic              o_is_end;

    // mirror of the parser state, all zero as after reset
    logic              rec_open   = 1'b0;
    logic [POS_W-1:0]  text_pos   = '0;
    logic [15:0]       digit_acc  = '0;
    logic              digit_bad  = 1'b0;
    logic [7:0]        rec_len    = '0;
    logic [15:0]       rec_addr   = '0;
    logic [7:0]        rec_type   = '0;
    logic [15:0]       seg_base   = '0;
    logic [15:0]       base_addr  = '0;
    logic              base_taken = 1'b0;
    logic              eof_seen   = 1'b0;

    t_result     expected_writes[$];
    int          fail_count  = 0;
    int          chars_sent  = 0;
    int          burst_left  = 0;
    bit          end_allowed = 1'b0;
    t_ready_mode ready_mode  = READY_ALWAYS;
    int          mode_left   = 0;
    int          ready_tick  = 0;

    intel_hex_record_parser_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_char_in       (i_char_in),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_write_address (o_write_address),
        .o_write_byte    (o_write_byte),
        .o_is_end        (o_is_end)
    );

    always #1 i_clk = ~i_clk;

    // positional record decoder: updates the mirrored state for one accepted
    // character and queues the write or end marker that it produces
    function automatic void decode_hex_char(input logic [7:0] c);
        int unsigned pos;
        int unsigned crc_pos;
        logic        seg_rec;
        logic        starts;
        logic        digit_ok;
        logic [3:0]  nib;
        logic [15:0] value;
        t_result     res;
        if (eof_seen) return;
        // outside a record only a colon matters
        if (!rec_open) begin
            if (c == CHAR_COLON) begin
                rec_open  = 1'b1;
                text_pos  = '0;
                digit_acc = '0;
                digit_bad = 1'b0;
            end
            return;
        end
        pos     = 32'(text_pos);
        crc_pos = 8 + 2 * rec_len;
        // a segment record reads its first four data digits as one field
        seg_rec = (rec_type == REC_SEG) && (rec_len >= 2);
        if (pos < 8) begin
            starts = (pos == 0 || pos == 2 || pos == 6);
        end else if (pos < crc_pos) begin
            starts = ((pos - 8) % 2 == 0) && !(seg_rec && pos == 10);
        end else begin
            starts = (pos == crc_pos);
        end
        if (starts) begin
            digit_acc = '0;
            digit_bad = 1'b0;
        end
        digit_ok = 1'b1;
        nib      = '0;
        if (c >= CHAR_0 && c <= CHAR_9) begin
            nib = 4'(c - CHAR_0);
        end else if (c >= CHAR_UA && c <= CHAR_UF) begin
            nib = 4'(c - CHAR_UA + 8'd10);
        end else if (c >= CHAR_LA && c <= CHAR_LF) begin
            nib = 4'(c - CHAR_LA + 8'd10);
        end else begin
            digit_ok = 1'b0;
        end
        if (!digit_ok) digit_bad = 1'b1;
        digit_acc = {digit_acc[11:0], nib};
        // any bad digit zeroes the whole field
        value = digit_bad ? 16'h0000 : digit_acc;
        if (pos == 1) begin
            rec_len = value[7:0];
        end else if (pos == 5) begin
            rec_addr = value;
            // the very first record after reset fixes the address origin
            if (!base_taken) begin
                base_addr  = value;
                base_taken = 1'b1;
            end
        end else if (pos == 7) begin
            rec_type = value[7:0];
        end else if (pos >= 8 && pos < crc_pos) begin
            if (rec_type == REC_DATA && (pos - 8) % 2 == 1) begin
                res.write_address = {4'h0, rec_addr} - {4'h0, base_addr}
                                  + {seg_base, 4'h0} + ADDR_W'((pos - 8) / 2);
                res.write_byte    = value[7:0];
                res.is_end        = 1'b0;
                expected_writes.push_back(res);
            end else if (seg_rec && pos == 11) begin
                // segment is replaced, never accumulated
                seg_base = value;
            end
        end else if (pos == crc_pos + 1) begin
            rec_open = 1'b0;
            if (rec_type == REC_EOF) begin
                res        = '0;
                res.is_end = 1'b1;
                expected_writes.push_back(res);
                eof_seen   = 1'b1;
            end
        end
        text_pos = POS_W'(pos + 1);
    endfunction

    function automatic void flag_mismatch(input string what, input t_result want,
                                          input t_result seen);
        fail_count++;
        if (fail_count <= 10) begin
            $display("%0t ns: %s: expected addr %05h byte %02h end %0b, %s %05h byte %02h end %0b",
                     $time, what, want.write_address, want.write_byte, want.is_end,
                     "got addr", seen.write_address, seen.write_byte, seen.is_end);
        end
    endfunction

    // hex digits with random letter case
    function automatic void push_hex(ref t_byte_q text, input logic [15:0] value,
                                     input int digits);
        logic [3:0] nib;
        for (int k = digits - 1; k >= 0; k--) begin
            nib = value[4*k +: 4];
            if (nib < 4'd10) begin
                text.push_back(CHAR_0 + 8'(nib));
            end else if ($urandom_range(0, 1) == 1) begin
                text.push_back(CHAR_UA + 8'(nib) - 8'd10);
            end else begin
                text.push_back(CHAR_LA + 8'(nib) - 8'd10);
            end
        end
    endfunction

    // one character transaction on the input channel; the sender runs in bursts
    // with random gaps, and the decoder mirror advances once the character is taken
    task automatic send_char(input logic [7:0] c_in);
        logic [7:0] c;
        int         gap;
        c = c_in;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 48);
        end
        burst_left--;
        // keep noise from forming an end record before the end-of-file test
        if (!end_allowed && rec_open && !eof_seen && text_pos == POS_W'(7) && !digit_bad
            && digit_acc[3:0] == 4'h0 && c == "1") begin
            c = "3";
        end
        i_valid   <= 1'b1;
        i_char_in <= c;
        do @(posedge i_clk); while (!o_ready);
        chars_sent++;
        decode_hex_char(c);
    endtask

    task automatic send_text(input string s);
        for (int k = 0; k < s.len(); k++) send_char(s[k]);
    endtask

    // full record with a correct checksum; bad_pct corrupts characters at random
    task automatic send_record(input logic [7:0] len, input logic [15:0] addr,
                               input logic [7:0] rtype, input t_byte_q data,
                               input int bad_pct);
        t_byte_q    text;
        logic [7:0] sum;
        logic [7:0] crc;
        sum = len + addr[15:8] + addr[7:0] + rtype;
        foreach (data[i]) sum += data[i];
        crc = ~sum + 8'd1;
        text.push_back(CHAR_COLON);
        push_hex(text, {8'h00, len}, 2);
        push_hex(text, addr, 4);
        push_hex(text, {8'h00, rtype}, 2);
        foreach (data[i]) push_hex(text, {8'h00, data[i]}, 2);
        push_hex(text, {8'h00, crc}, 2);
        foreach (text[i]) begin
            if ($urandom_range(0, 99) < bad_pct) begin
                text[i] = ($urandom_range(0, 3) == 0) ? CHAR_COLON : 8'($urandom_range(0, 255));
            end
            send_char(text[i]);
        end
    endtask

    // data records at the field extremes, leading noise, address wrap below origin
    task automatic test_data_records();
        t_byte_q data;
        send_char(8'h00);
        send_char(8'hFF);
        send_char(8'h7F);
        send_text("0Fz");
        data = {8'h00, 8'hFF, 8'h5A, 8'hA5};
        send_record(8'd4, 16'h1234, REC_DATA, data, 0);
        data = {8'hC3};
        send_record(8'd1, 16'h0000, REC_DATA, data, 0);
        data = {8'h80, 8'h01};
        send_record(8'd2, 16'hFFFF, REC_DATA, data, 0);
        data = {};
        send_record(8'd0, 16'h4000, REC_DATA, data, 0);
        send_text(":04123800abCdeF0135");
    endtask

    // segment load, replace, short records that leave it alone, wrap past 2^20
    task automatic test_segment_records();
        t_byte_q data;
        t_byte_q probe;
        probe = {8'h11, 8'h22};
        data  = {8'hFF, 8'hFF};
        send_record(8'd2, 16'h0000, REC_SEG, data, 0);
        send_record(8'd2, 16'h1234, REC_DATA, probe, 0);
        send_record(8'd2, 16'hFFFF, REC_DATA, probe, 0);
        data = {8'h00, 8'h10};
        send_record(8'd2, 16'h0000, REC_SEG, data, 0);
        send_record(8'd2, 16'h1234, REC_DATA, probe, 0);
        // too short to carry a segment
        data = {};
        send_record(8'd0, 16'h0000, REC_SEG, data, 0);
        data = {8'h77};
        send_record(8'd1, 16'h0000, REC_SEG, data, 0);
        send_record(8'd2, 16'h1234, REC_DATA, probe, 0);
        data = {8'h12, 8'h34, 8'h56, 8'h78};
        send_record(8'd4, 16'h0000, REC_SEG, data, 0);
        send_record(8'd2, 16'h1240, REC_DATA, probe, 0);
        data = {8'h00, 8'h00};
        send_record(8'd2, 16'h0000, REC_SEG, data, 0);
    endtask

    // bad digits in the length, address, type and data fields, colon inside a record, unsupported types
    task automatic test_malformed_records();
        t_byte_q data;
        send_text(":0212340004:999");
        send_text(":02G23400010200");
        send_text(":0X1234000102");
        send_text(":0112340G55AA");
        send_text(":021234005g7700");
        send_text("::1234000000");
        data = {8'h01, 8'h02};
        send_record(8'd2, 16'h1234, 8'h03, data, 0);
        send_record(8'd2, 16'h1234, 8'h04, data, 0);
        send_record(8'd2, 16'h1234, 8'h05, data, 0);
        send_record(8'd2, 16'h1234, 8'hFF, data, 0);
    endtask

    // mostly well-formed records with random content, some noise and damage
    task automatic test_random_records();
        t_byte_q    data;
        logic [7:0] len;
        logic [7:0] rtype;
        int         pick;
        int         n;
        int         bad_pct;
        while (chars_sent < RANDOM_CHAR_TARGET) begin
            if ($urandom_range(0, 4) == 0) begin
                repeat ($urandom_range(1, 6)) send_char(8'($urandom_range(0, 255)));
            end
            pick = $urandom_range(0, 99);
            if (pick < 2) begin
                len = 8'($urandom_range(41, 255));
            end else if (pick < 25) begin
                len = 8'($urandom_range(17, 40));
            end else begin
                len = 8'($urandom_range(0, 16));
            end
            pick = $urandom_range(0, 99);
            if (pick < 75) begin
                rtype = REC_DATA;
            end else if (pick < 88) begin
                rtype = REC_SEG;
                len   = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 4)) : 8'd2;
            end else begin
                rtype = ($urandom_range(0, 1) == 1) ? 8'($urandom_range(3, 5))
                                                   : 8'($urandom_range(3, 255));
            end
            n       = int'(len);
            bad_pct = 0;
            // damaged record: stray characters and sometimes a wrong data count
            if ($urandom_range(0, 7) == 0) begin
                bad_pct = $urandom_range(2, 15);
                if ($urandom_range(0, 1) == 1) n = $urandom_range(0, n + 3);
            end
            data.delete();
            repeat (n) data.push_back(8'($urandom_range(0, 255)));
            send_record(len, 16'($urandom_range(0, 65535)), rtype, data, bad_pct);
        end
    endtask

    // end record, then input that must all be ignored
    task automatic test_end_of_file();
        t_byte_q data;
        // finish whatever record a damaged one left open
        while (rec_open) send_char("G");
        send_text("x\r\n");
        end_allowed = 1'b1;
        data.delete();
        repeat ($urandom_range(0, 3)) data.push_back(8'($urandom_range(0, 255)));
        send_record(8'(data.size()), 16'($urandom_range(0, 65535)), REC_EOF, data, 0);
        send_text(":0112340055AA");
        send_text(":00000001FF");
        repeat (12) send_char(8'($urandom_range(0, 255)));
        i_valid <= 1'b0;
    endtask

    // receiver stall pattern
    always @(posedge i_clk) begin
        if (mode_left == 0) begin
            ready_mode = t_ready_mode'($urandom_range(0, 3));
            mode_left  = $urandom_range(16, 200);
        end
        mode_left--;
        ready_tick++;
        case (ready_mode)
            READY_ALWAYS:       i_ready <= 1'b1;
            READY_RANDOM:       i_ready <= ($urandom_range(0, 9) < 7);
            READY_EVERY_FOURTH: i_ready <= (ready_tick % 4 == 0);
            default:            i_ready <= ($urandom_range(0, 19) == 0);
        endcase
    end

    // result checker: each accepted transaction against the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_result seen;
        t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            seen.write_address = o_write_address;
            seen.write_byte    = o_write_byte;
            seen.is_end        = o_is_end;
            if (expected_writes.size() == 0) begin
                flag_mismatch("unexpected result", '0, seen);
            end else begin
                want = expected_writes.pop_front();
                if (seen.write_address !== want.write_address) begin
                    flag_mismatch("write_address", want, seen);
                end else if (seen.write_byte !== want.write_byte) begin
                    flag_mismatch("write_byte", want, seen);
                end else if (seen.is_end !== want.is_end) begin
                    flag_mismatch("is_end", want, seen);
                end
            end
        end
    end

    initial begin : run_tests
        int waited;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_data_records();
        test_segment_records();
        test_malformed_records();
        test_random_records();
        test_end_of_file();
        // let the pipeline drain, then a short quiet tail
        waited = 0;
        while (expected_writes.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (expected_writes.size() != 0) begin
            fail_count++;
            $display("%0d expected results never arrived", expected_writes.size());
        end
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/ihex_pkg.sv
hw/rtl/ihex_in_stage.sv
hw/rtl/ihex_core.sv
hw/rtl/ihex_out_stage.sv
hw/rtl/intel_hex_record_parser_top.sv
hw/rtl/ihex_checker.sv
tb/tb.sv
